>>> hdl/slid_pkg.sv
// Shared types and constants for the sorted list insert/delete unit.
`default_nettype none

package slid_pkg;

    // Default number of list cells
    localparam int DEFAULT_CAPACITY = 16;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_DELETED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic ins;  // insert, list not full
        logic del;  // delete, a match exists
    } cell_op_t;

endpackage

`default_nettype wire

>>> hdl/slid_cell.sv
// One list cell: holds one entry and shifts with its neighbors.
`default_nettype none

module slid_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire slid_pkg::cell_op_t op,
    input  wire logic signed [7:0] value,
    input  wire logic signed [7:0] left_entry,
    input  wire logic              left_valid,
    input  wire logic              left_ge,
    input  wire logic signed [7:0] right_entry,
    input  wire logic              right_valid,
    output logic signed [7:0]      entry,
    output logic                   valid,
    output logic                   ge,
    output logic                   eq
);

    logic signed [7:0] entry_reg, entry_next;
    logic              valid_reg, valid_next;

    // Empty cells count as larger than any value
    assign ge    = !valid_reg || (entry_reg >= value);
    assign eq    = valid_reg && (entry_reg == value);
    assign entry = entry_reg;
    assign valid = valid_reg;

    // Shift logic: insert moves toward the tail, delete toward the head
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (op.ins)
        begin
            if (left_ge)
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
            else if (ge)
            begin
                entry_next = value;
                valid_next = 1'b1;
            end
        end
        else if (op.del)
        begin
            if (ge)
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> hdl/sorted_list_insert_delete_unit.sv
// Top level of the sorted list insert/delete unit.
`default_nettype none

// Sorted list of signed 8-bit values, ascending, duplicates allowed.
// Command channel: a word (action, value) is taken on a clock edge with
// start high and busy low. busy is always low: the list never stalls.
// action 0 inserts value before the first entry not smaller than it;
// action 1 deletes the first entry equal to value.
// Result channel: one word per command, shown on status and entry_count
// for exactly one cycle with done high, in the cycle after the command.
// The receiver cannot hold it off and needs none: a new command may be
// given in every cycle, so throughput is one command per cycle.
// The list is a row of CAPACITY cells; each compares its entry with the
// broadcast value and takes its neighbor's entry in the same cycle. The
// match flags are OR-ed across the row to decide whether a delete hits.
// Reset clears the entry count and all cell valid flags; no result is
// pending after reset.

module sorted_list_insert_delete_unit #(
    parameter int CAPACITY = slid_pkg::DEFAULT_CAPACITY
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              action,
    input  wire logic signed [7:0] value,
    output logic                   done,
    output logic [1:0]             status,
    output logic [4:0]             entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [7:0]  entry_vec [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] ge_vec;
    logic [CAPACITY-1:0] eq_vec;

    logic [CW-1:0]      count_reg, count_next;
    logic               done_reg;
    slid_pkg::status_t  status_reg, status_next;
    logic [31:0]        count_ext;

    slid_pkg::cell_op_t op;
    logic               accept;
    logic               full;
    logic               found;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(CAPACITY));
    assign found  = |eq_vec;

    // Command decode
    always_comb
    begin
        op.ins = accept && !action && !full;
        op.del = accept && action && found;
    end

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [7:0] l_entry, r_entry;
            logic              l_valid, l_ge, r_valid;

            if (gi == 0)
            begin : g_head
                assign l_entry = value;
                assign l_valid = 1'b1;
                assign l_ge    = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_entry = entry_vec[gi-1];
                assign l_valid = valid_vec[gi-1];
                assign l_ge    = ge_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_entry = 8'sd0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_entry = entry_vec[gi+1];
                assign r_valid = valid_vec[gi+1];
            end

            slid_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .value       (value),
                .left_entry  (l_entry),
                .left_valid  (l_valid),
                .left_ge     (l_ge),
                .right_entry (r_entry),
                .right_valid (r_valid),
                .entry       (entry_vec[gi]),
                .valid       (valid_vec[gi]),
                .ge          (ge_vec[gi]),
                .eq          (eq_vec[gi])
            );
        end
    endgenerate

    // Count and status
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            if (!action)
            begin
                if (full)
                begin
                    status_next = slid_pkg::ST_FULL;
                end
                else
                begin
                    status_next = slid_pkg::ST_INSERTED;
                    count_next  = count_reg + CW'(1);
                end
            end
            else
            begin
                if (found)
                begin
                    status_next = slid_pkg::ST_DELETED;
                    count_next  = count_reg - CW'(1);
                end
                else
                begin
                    status_next = slid_pkg::ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Status payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign count_ext   = 32'(count_reg);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = count_ext[4:0];

`ifndef SYNTHESIS
    // A result only follows a command
    a_done_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start))
        else $error("result word without a command");

    // Valid cells always match the entry count
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("valid cells disagree with entry count");

    // An insert grows the list by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == slid_pkg::ST_INSERTED) |->
            (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    // Count never exceeds the cell count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("entry count beyond capacity");
`endif

endmodule

`default_nettype wire
